// ===== src/dkss_pkg.sv =====
// ----------------------------------------------------------------------------
// dkss_pkg
// Types and constants for the debounced key speed setpoint block.
// ----------------------------------------------------------------------------
package dkss_pkg;

  localparam int SPEED_W = 16;
  localparam int STEP_W  = SPEED_W - 1;
  localparam int DB_W    = 20;
  localparam int CFG_W   = DB_W;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESET_SPEED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MAX      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 3'd4;

  localparam logic        [STEP_W-1:0]  STEP_SIZE_RST      = 15'd512;
  localparam logic signed [SPEED_W-1:0] PRESET_SPEED_RST   = 16'sd2560;
  localparam logic signed [SPEED_W-1:0] SPEED_MIN_RST      = -16'sd5120;
  localparam logic signed [SPEED_W-1:0] SPEED_MAX_RST      = 16'sd5120;
  localparam logic        [DB_W-1:0]    DEBOUNCE_TICKS_RST = 20'd30000;

  localparam logic [1:0] KEY_STOP   = 2'd0;
  localparam logic [1:0] KEY_DOWN   = 2'd1;
  localparam logic [1:0] KEY_PRESET = 2'd2;
  localparam logic [1:0] KEY_UP     = 2'd3;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_RELEASE  = 2'd2
  } phase_t;

  typedef struct packed {
    logic                      op;
    logic [3:0]                key_levels;
    logic signed [SPEED_W-1:0] set_speed;
  } item_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] target_speed;
    logic                      target_written;
    logic                      busy_res;
  } result_t;

  typedef struct packed {
    logic       found;
    logic [1:0] key;
  } scan_t;

  // first pressed key with index >= from
  function automatic scan_t first_key(logic [3:0] pressed, logic [2:0] from);
    scan_t s;
    s.found = 1'b0;
    s.key   = KEY_STOP;
    for (int k = 3; k >= 0; k--) begin
      if (pressed[k] && (3'(k) >= from)) begin
        s.found = 1'b1;
        s.key   = 2'(k);
      end
    end
    return s;
  endfunction

  function automatic logic signed [SPEED_W-1:0] clamp_speed(
      logic signed [SPEED_W:0]   v,
      logic signed [SPEED_W-1:0] lo,
      logic signed [SPEED_W-1:0] hi);
    logic signed [SPEED_W:0] lo_x;
    logic signed [SPEED_W:0] hi_x;
    lo_x = {lo[SPEED_W-1], lo};
    hi_x = {hi[SPEED_W-1], hi};
    if (v < lo_x) begin
      return lo;
    end else if (v > hi_x) begin
      return hi;
    end
    return v[SPEED_W-1:0];
  endfunction

endpackage

// ===== src/dkss_core.sv =====
// ----------------------------------------------------------------------------
// dkss_core
// Configuration registers, key debounce state machine and saturating setpoint.
// ----------------------------------------------------------------------------
module dkss_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wen,
  input  logic [dkss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dkss_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              accept,
  input  dkss_pkg::item_t                   item,
  output dkss_pkg::result_t                 res
);

  logic        [dkss_pkg::STEP_W-1:0]  step_size;
  logic signed [dkss_pkg::SPEED_W-1:0] preset_speed;
  logic signed [dkss_pkg::SPEED_W-1:0] speed_min;
  logic signed [dkss_pkg::SPEED_W-1:0] speed_max;
  logic        [dkss_pkg::DB_W-1:0]    debounce_ticks;

  logic signed [dkss_pkg::SPEED_W-1:0] setpoint;
  logic signed [dkss_pkg::SPEED_W-1:0] setpoint_next;
  dkss_pkg::phase_t                    phase;
  dkss_pkg::phase_t                    phase_next;
  logic [1:0]                          active_key;
  logic [1:0]                          active_key_next;
  logic [dkss_pkg::DB_W-1:0]           debounce_count;
  logic [dkss_pkg::DB_W-1:0]           debounce_count_next;

  logic [3:0]                          pressed;
  logic signed [dkss_pkg::SPEED_W:0]   sp_x;
  logic signed [dkss_pkg::SPEED_W:0]   step_x;
  logic signed [dkss_pkg::SPEED_W:0]   set_x;
  dkss_pkg::scan_t                     scan_all;
  dkss_pkg::scan_t                     scan_rest;
  logic                                written;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size      <= dkss_pkg::STEP_SIZE_RST;
      preset_speed   <= dkss_pkg::PRESET_SPEED_RST;
      speed_min      <= dkss_pkg::SPEED_MIN_RST;
      speed_max      <= dkss_pkg::SPEED_MAX_RST;
      debounce_ticks <= dkss_pkg::DEBOUNCE_TICKS_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        dkss_pkg::CFG_STEP_SIZE:      step_size      <= cfg_data[dkss_pkg::STEP_W-1:0];
        dkss_pkg::CFG_PRESET_SPEED:   preset_speed   <= cfg_data[dkss_pkg::SPEED_W-1:0];
        dkss_pkg::CFG_SPEED_MIN:      speed_min      <= cfg_data[dkss_pkg::SPEED_W-1:0];
        dkss_pkg::CFG_SPEED_MAX:      speed_max      <= cfg_data[dkss_pkg::SPEED_W-1:0];
        dkss_pkg::CFG_DEBOUNCE_TICKS: debounce_ticks <= cfg_data[dkss_pkg::DB_W-1:0];
        default: ;
      endcase
    end
  end

  assign pressed   = ~item.key_levels;
  assign sp_x      = {setpoint[dkss_pkg::SPEED_W-1], setpoint};
  assign step_x    = {2'b00, step_size};
  assign set_x     = {item.set_speed[dkss_pkg::SPEED_W-1], item.set_speed};
  assign scan_all  = dkss_pkg::first_key(pressed, 3'd0);
  assign scan_rest = dkss_pkg::first_key(pressed, {1'b0, active_key} + 3'd1);

  always_comb begin
    setpoint_next       = setpoint;
    phase_next          = phase;
    active_key_next     = active_key;
    debounce_count_next = debounce_count;
    written             = 1'b0;
    if (item.op == dkss_pkg::OP_SET) begin
      setpoint_next = dkss_pkg::clamp_speed(set_x, speed_min, speed_max);
      written       = 1'b1;
    end else begin
      case (phase)
        dkss_pkg::PH_DEBOUNCE: begin
          if (debounce_count > dkss_pkg::DB_W'(1)) begin
            debounce_count_next = debounce_count - dkss_pkg::DB_W'(1);
          end else if (pressed[active_key]) begin
            written    = 1'b1;
            phase_next = dkss_pkg::PH_RELEASE;
            case (active_key)
              dkss_pkg::KEY_STOP:   setpoint_next = '0;
              dkss_pkg::KEY_DOWN:   setpoint_next = dkss_pkg::clamp_speed(sp_x - step_x,
                                                      speed_min, speed_max);
              dkss_pkg::KEY_PRESET: setpoint_next = preset_speed;
              default:              setpoint_next = dkss_pkg::clamp_speed(sp_x + step_x,
                                                      speed_min, speed_max);
            endcase
          end else if (scan_rest.found) begin
            active_key_next     = scan_rest.key;
            debounce_count_next = debounce_ticks;
            phase_next          = dkss_pkg::PH_DEBOUNCE;
          end else begin
            phase_next = dkss_pkg::PH_IDLE;
          end
        end
        dkss_pkg::PH_RELEASE: begin
          if (!pressed[active_key]) begin
            phase_next = dkss_pkg::PH_IDLE;
          end
        end
        default: begin
          if (scan_all.found) begin
            active_key_next     = scan_all.key;
            debounce_count_next = debounce_ticks;
            phase_next          = dkss_pkg::PH_DEBOUNCE;
          end else begin
            phase_next = dkss_pkg::PH_IDLE;
          end
        end
      endcase
    end
  end

  always_comb begin
    res.target_speed   = setpoint_next;
    res.target_written = written;
    res.busy_res       = (phase_next == dkss_pkg::PH_DEBOUNCE) ||
                         (phase_next == dkss_pkg::PH_RELEASE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint       <= '0;
      phase          <= dkss_pkg::PH_IDLE;
      active_key     <= dkss_pkg::KEY_STOP;
      debounce_count <= '0;
    end else if (accept) begin
      setpoint       <= setpoint_next;
      phase          <= phase_next;
      active_key     <= active_key_next;
      debounce_count <= debounce_count_next;
    end
  end

endmodule

// ===== src/dkss_obuf.sv =====
// ----------------------------------------------------------------------------
// dkss_obuf
// Result register with a skid entry so a new transaction lands while stalled.
// ----------------------------------------------------------------------------
module dkss_obuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dkss_pkg::result_t push_data,
  output logic              full,
  output logic              result_valid,
  input  logic              result_stall,
  output dkss_pkg::result_t result
);

  logic              skid_valid;
  dkss_pkg::result_t skid;
  logic              take;

  assign take = result_valid && !result_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (take || !result_valid) begin
      if (skid_valid) begin
        result       <= skid;
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else if (push) begin
        result       <= push_data;
        result_valid <= 1'b1;
      end else begin
        result_valid <= 1'b0;
      end
    end else if (push) begin
      skid       <= push_data;
      skid_valid <= 1'b1;
    end
  end

endmodule

// ===== src/debounced_key_speed_setpoint.sv =====
// ----------------------------------------------------------------------------
// debounced_key_speed_setpoint
// Debounced stop/down/preset/up keys driving a saturating Q8.8 speed setpoint.
// ----------------------------------------------------------------------------
//   channel   handshake                  payload
//   item      item_valid / item_stall    item   (op, key_levels, set_speed)
//   result    result_valid / result_stall result (target_speed, written, busy)
//   config    cfg_wen                    cfg_index, cfg_data
//
// One transaction per clock while item_stall is low; the result is registered.
// The state machine and saturating adder settle in the accept cycle.
// A skid entry holds one more result, so item_stall rises only with two pending.
// Synchronous reset loads the register defaults and clears the setpoint.
// ----------------------------------------------------------------------------
module debounced_key_speed_setpoint (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  dkss_pkg::item_t                item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output dkss_pkg::result_t              result,
  input  logic                           cfg_wen,
  input  logic [dkss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dkss_pkg::CFG_W-1:0]     cfg_data
);

  logic              accept;
  dkss_pkg::result_t res;

  assign accept = item_valid && !item_stall;

  dkss_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (item),
    .res       (res)
  );

  dkss_obuf u_obuf (
    .clk          (clk),
    .rst          (rst),
    .push         (accept),
    .push_data    (res),
    .full         (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("skid occupied with empty result register");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("accepted transaction produced no result");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!item_stall && !result_valid))
    else $error("buffers not empty after reset");

endmodule

// ===== verif/setpoint_checker.sv =====
// ----------------------------------------------------------------------------
// setpoint_checker
// Watches the item, result and config channels of the debounced key speed
// setpoint block, runs its own model of the key state machine and saturating
// setpoint, and compares every result transaction field by field.
// ----------------------------------------------------------------------------
module setpoint_checker import dkss_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 item_stall,
  input  item_t                item,
  input  logic                 result_valid,
  input  logic                 result_stall,
  input  result_t              result,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   pending,
  output int                   mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  logic        [STEP_W-1:0]  step_size;
  logic signed [SPEED_W-1:0] preset_speed;
  logic signed [SPEED_W-1:0] speed_min;
  logic signed [SPEED_W-1:0] speed_max;
  logic        [DB_W-1:0]    debounce_ticks;

  logic signed [SPEED_W-1:0] setpoint;
  phase_t                    phase;
  logic [1:0]                active_key;
  logic [DB_W-1:0]           debounce_left;

  result_t expected_setpoints[$];

  function automatic int saturate(int v);
    int lo;
    int hi;
    lo = speed_min;
    hi = speed_max;
    if (v < lo) begin
      return lo;
    end else if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  // lowest pressed key at or above 'from' starts a debounce, else idle
  function automatic void start_debounce(logic [3:0] levels, int from);
    phase = PH_IDLE;
    for (int k = 3; k >= from; k--) begin
      if (!levels[k]) begin
        active_key    = 2'(k);
        debounce_left = debounce_ticks;
        phase         = PH_DEBOUNCE;
      end
    end
  endfunction

  function automatic void apply_key();
    int cur;
    int stp;
    cur = setpoint;
    stp = step_size;
    case (active_key)
      KEY_STOP:   setpoint = '0;
      KEY_DOWN:   setpoint = SPEED_W'(saturate(cur - stp));
      KEY_PRESET: setpoint = preset_speed;
      default:    setpoint = SPEED_W'(saturate(cur + stp));
    endcase
  endfunction

  function automatic result_t next_setpoint(item_t it);
    result_t r;
    logic    wr;
    int      req;
    wr = 1'b0;
    if (it.op == OP_SET) begin
      req      = $signed(it.set_speed);
      setpoint = SPEED_W'(saturate(req));
      wr       = 1'b1;
    end else begin
      case (phase)
        PH_DEBOUNCE: begin
          if (debounce_left > 1) begin
            debounce_left = debounce_left - 1'b1;
          end else if (!it.key_levels[active_key]) begin
            apply_key();
            wr    = 1'b1;
            phase = PH_RELEASE;
          end else begin
            start_debounce(it.key_levels, int'(active_key) + 1);
          end
        end
        PH_RELEASE: begin
          if (it.key_levels[active_key]) begin
            phase = PH_IDLE;
          end
        end
        default: start_debounce(it.key_levels, 0);
      endcase
    end
    r.target_speed   = setpoint;
    r.target_written = wr;
    r.busy_res       = (phase == PH_DEBOUNCE) || (phase == PH_RELEASE);
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      step_size      = STEP_SIZE_RST;
      preset_speed   = PRESET_SPEED_RST;
      speed_min      = SPEED_MIN_RST;
      speed_max      = SPEED_MAX_RST;
      debounce_ticks = DEBOUNCE_TICKS_RST;
      setpoint       = '0;
      phase          = PH_IDLE;
      active_key     = KEY_STOP;
      debounce_left  = '0;
      mismatches     = 0;
      expected_setpoints.delete();
      pending <= 0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          CFG_STEP_SIZE:      step_size      = cfg_data[STEP_W-1:0];
          CFG_PRESET_SPEED:   preset_speed   = cfg_data[SPEED_W-1:0];
          CFG_SPEED_MIN:      speed_min      = cfg_data[SPEED_W-1:0];
          CFG_SPEED_MAX:      speed_max      = cfg_data[SPEED_W-1:0];
          CFG_DEBOUNCE_TICKS: debounce_ticks = cfg_data[DB_W-1:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (expected_setpoints.size() == 0) begin
          $error("result transaction with nothing pending: speed %0d", result.target_speed);
          mismatches++;
        end else begin
          want = expected_setpoints.pop_front();
          if (result.target_speed !== want.target_speed) begin
            $error("target_speed: expected %0d, got %0d",
                   want.target_speed, result.target_speed);
            mismatches++;
          end
          if (result.target_written !== want.target_written) begin
            $error("target_written: expected %0b, got %0b",
                   want.target_written, result.target_written);
            mismatches++;
          end
          if (result.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0b, got %0b", want.busy_res, result.busy_res);
            mismatches++;
          end
        end
      end
      if (item_valid && !item_stall) begin
        expected_setpoints.push_back(next_setpoint(item));
      end
      pending <= expected_setpoints.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the debounced key speed setpoint block: a directed pass over
// every key, bounce, release and clamp case, then random key sessions under
// several register settings, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dkss_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 250;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  item_t                item = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;
  logic                 cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  int              outstanding;
  int              mismatches;
  logic            rx_hold_req = 1'b0;
  int              burst_left = 0;
  int              items_sent = 0;
  logic [DB_W-1:0] cur_debounce = DEBOUNCE_TICKS_RST;

  debounced_key_speed_setpoint dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  setpoint_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pending      (outstanding),
    .mismatches   (mismatches)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic item_t key_tick(logic [3:0] levels);
    item_t t;
    t.op         = OP_TICK;
    t.key_levels = levels;
    t.set_speed  = SPEED_W'($urandom);
    return t;
  endfunction

  function automatic item_t speed_write(logic signed [SPEED_W-1:0] spd);
    item_t t;
    t.op         = OP_SET;
    t.key_levels = 4'($urandom);
    t.set_speed  = spd;
    return t;
  endfunction

  function automatic logic signed [SPEED_W-1:0] random_speed();
    case ($urandom_range(0, 5))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      default: return SPEED_W'($urandom);
    endcase
  endfunction

  task automatic send_item(item_t t);
    int gap;
    item       <= t;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic load_config(logic [STEP_W-1:0] stp, logic signed [SPEED_W-1:0] pre,
                             logic signed [SPEED_W-1:0] lo, logic signed [SPEED_W-1:0] hi,
                             logic [DB_W-1:0] dbt);
    logic [CFG_W-1:0]     fill;
    logic [CFG_W-1:0]     words [6];
    logic [CFG_IDX_W-1:0] regs [6];
    fill     = CFG_W'($urandom);
    words[0] = {fill[CFG_W-1:STEP_W], stp};
    words[1] = {fill[CFG_W-1:SPEED_W], pre};
    words[2] = {~fill[CFG_W-1:SPEED_W], lo};
    words[3] = {fill[CFG_W-1:SPEED_W], hi};
    words[4] = dbt;
    words[5] = CFG_W'($urandom);
    regs = '{CFG_STEP_SIZE, CFG_PRESET_SPEED, CFG_SPEED_MIN, CFG_SPEED_MAX,
             CFG_DEBOUNCE_TICKS, CFG_IDX_SPARE};
    for (int i = 0; i < 6; i++) begin
      cfg_wen   <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= words[i];
      @(posedge clk);
    end
    cfg_wen      <= 1'b0;
    cur_debounce  = dbt;
  endtask

  // one press: hold a key set with some bounce, then release
  task automatic key_session();
    logic [3:0] held;
    logic [3:0] lv;
    int         eff;
    int         hold_len;
    int         rel_len;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 1) == 0) send_item(speed_write(random_speed()));
        else send_item(key_tick(4'($urandom)));
      end
    end
    held = 4'(1 << $urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) held = held | 4'($urandom);
    eff      = (cur_debounce > 8) ? 8 : int'(cur_debounce);
    hold_len = $urandom_range(0, 2 * eff + 4);
    rel_len  = $urandom_range(1, 4);
    for (int i = 0; i < hold_len + rel_len; i++) begin
      lv = (i < hold_len) ? ~held : 4'hF;
      if ($urandom_range(0, 7) == 0) lv = 4'($urandom);
      if ($urandom_range(0, 23) == 0) send_item(speed_write(random_speed()));
      send_item(key_tick(lv));
    end
  endtask

  // receiver: stall pattern in segments, plus one long hold-off on request
  initial begin
    int seg_len;
    int stall_pct;
    int hold_left;
    hold_left = 0;
    forever begin
      seg_len = $urandom_range(4, 64);
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 20;
        2:       stall_pct = 50;
        default: stall_pct = 85;
      endcase
      repeat (seg_len) begin
        @(posedge clk);
        if (hold_left == 0 && rx_hold_req) begin
          rx_hold_req = 1'b0;
          hold_left   = RX_HOLD_CYCLES;
        end
        if (hold_left != 0) begin
          hold_left--;
          result_stall <= 1'b1;
        end else begin
          result_stall <= ($urandom_range(0, 99) < stall_pct);
        end
      end
    end
  end

  initial begin
    item_t plan[$];
    int    goal;
    logic  paused;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset register values: clamps only, keys left released
    plan = '{speed_write(16'sh7FFF), speed_write(16'sh8000), key_tick(4'hF),
             speed_write(16'sd100)};
    foreach (plan[i]) send_item(plan[i]);
    drain_results();
    repeat (2) @(posedge clk);

    load_config(15'd512, 16'sd2560, -16'sd5120, 16'sd5120, '0);
    plan = '{
      key_tick(4'b1110), key_tick(4'b1110),   // stop
      key_tick(4'b1101),                      // stop released, down ignored this tick
      key_tick(4'b1101), key_tick(4'b1101), key_tick(4'hF),
      key_tick(4'b1011), key_tick(4'b1011), key_tick(4'hF),
      key_tick(4'b0111), speed_write(16'sd5000), key_tick(4'b0111), key_tick(4'hF),
      key_tick(4'b0110), key_tick(4'b0111),   // stop bounces, up takes over
      key_tick(4'b0111), key_tick(4'hF),
      key_tick(4'b1011), key_tick(4'hF),      // preset bounces, nothing else pressed
      key_tick(4'b0000), key_tick(4'b0000), key_tick(4'hF),
      speed_write(16'sh8000), key_tick(4'b1101), key_tick(4'b1101), key_tick(4'hF)
    };
    foreach (plan[i]) send_item(plan[i]);
    drain_results();
    repeat (2) @(posedge clk);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: load_config(STEP_W'($urandom), SPEED_W'($urandom), 16'sh8000, 16'sh7FFF, 20'd1);
        1: load_config(15'h7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 20'd2);
        2: load_config('0, 16'sh8000, -16'sd1000, 16'sd1000, '0);
        3: load_config(STEP_W'($urandom_range(1, 2000)), SPEED_W'($urandom),
                       16'sd1000, -16'sd1000, 20'd3);
        4: load_config(STEP_W'($urandom_range(0, 3000)), SPEED_W'($urandom),
                       -16'sd6000, 16'sd6000, DB_W'($urandom_range(0, 6)));
        default: load_config(STEP_W'($urandom), SPEED_W'($urandom), SPEED_W'($urandom),
                             SPEED_W'($urandom), DB_W'($urandom_range(0, 3)));
      endcase
      if (p == 1) rx_hold_req = 1'b1;
      goal   = items_sent + PHASE_ITEMS;
      paused = 1'b0;
      while (items_sent < goal) begin
        key_session();
        if (p == 3 && !paused && items_sent > goal - PHASE_ITEMS / 2) begin
          drain_results();
          paused = 1'b1;
        end
      end
      drain_results();
      repeat (2) @(posedge clk);
    end

    // longest debounce: a press never confirms within the run
    load_config(15'h7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 20'hFFFFF);
    send_item(key_tick(4'b0111));
    repeat (20) begin
      if ($urandom_range(0, 3) == 0) send_item(speed_write(random_speed()));
      else send_item(key_tick(4'($urandom)));
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
